// ===== hdl/crbm_pkg.sv =====
`timescale 1ns / 1ps

package crbm_pkg;

  // Characters the matcher looks for
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_EIGHT  = 8'h38;  // '8'
  localparam logic [7:0] CH_UPPER_A = 8'h41; // 'A'
  localparam logic [7:0] CH_UPPER_T = 8'h54; // 'T'
  localparam logic [7:0] CH_UPPER_E = 8'h45; // 'E'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'

  localparam int unsigned PREFIX_LEN = 8;
  localparam int unsigned PREFIX_ALT = 3;

  // Three accepted characters for each prefix position
  localparam logic [7:0] PREFIX_TAB [PREFIX_LEN][PREFIX_ALT] = '{
    '{8'h70, 8'h45, 8'h54},  // p E T
    '{8'h61, 8'h52, 8'h43},  // a R C
    '{8'h72, 8'h52, 8'h4D},  // r R M
    '{8'h61, 8'h6F, 8'h51},  // a o Q
    '{8'h6D, 8'h52, 8'h54},  // m R T
    '{8'h73, 8'h3A, 8'h54},  // s : T
    '{8'h22, 8'h32, 8'h53},  // " 2 S
    '{8'h3A, 8'h30, 8'h54}   // : 0 T
  };

  // Matcher states, one-hot
  typedef enum logic [14:0] {
    ST_P0         = 15'h0001,
    ST_P1         = 15'h0002,
    ST_P2         = 15'h0004,
    ST_P3         = 15'h0008,
    ST_P4         = 15'h0010,
    ST_P5         = 15'h0020,
    ST_P6         = 15'h0040,
    ST_P7         = 15'h0080,
    ST_P8         = 15'h0100,
    ST_PAYLOAD    = 15'h0200,
    ST_SKIP       = 15'h0400,
    ST_LINK_T     = 15'h0800,
    ST_LINK_E     = 15'h1000,
    ST_LINK_COLON = 15'h2000,
    ST_LINK_DIGIT = 15'h4000
  } match_st_t;

  // Architectural state carried from byte to byte
  typedef struct packed {
    match_st_t  mst;
    logic [7:0] count;
    logic       pending;
    logic       link;
  } crbm_state_t;

  // One result beat
  typedef struct packed {
    logic       capture_valid;
    logic [6:0] capture_index;
    logic [7:0] capture_byte;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       frame_dropped;
    logic       capture_overflow;
    logic       link_update;
    logic       link_connected;
  } crbm_res_t;

  // True when b is one of the characters allowed at prefix position pos
  function automatic logic prefix_hit(input logic [2:0] pos, input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < PREFIX_ALT; i++) begin
      if (b == PREFIX_TAB[pos][i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== hdl/crbm_step.sv =====
`timescale 1ns / 1ps

module crbm_step
  import crbm_pkg::*;
#(
  parameter int CAPTURE_DEPTH = 128
) (
  input  crbm_state_t cur,
  input  logic [7:0]  rx_byte,
  input  logic        frame_taken,
  output crbm_state_t nxt,
  output crbm_res_t   res
);

  logic       pend_eff;
  logic       room;
  logic       term;
  logic [7:0] cnt_inc;

  assign pend_eff = cur.pending & ~frame_taken;
  assign room     = cur.count < 8'(CAPTURE_DEPTH);
  assign term     = (rx_byte == CH_RBRACE) || (rx_byte == CH_LF);
  assign cnt_inc  = room ? cur.count + 8'd1 : cur.count;

  // Next state and result for one byte
  always_comb begin
    nxt         = cur;
    nxt.pending = pend_eff;
    res         = '0;

    case (cur.mst)
      ST_P0: begin
        if (prefix_hit(3'd0, rx_byte)) nxt.mst = ST_P1;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P1: begin
        if (prefix_hit(3'd1, rx_byte)) nxt.mst = ST_P2;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P2: begin
        if (prefix_hit(3'd2, rx_byte)) nxt.mst = ST_P3;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P3: begin
        if (prefix_hit(3'd3, rx_byte)) nxt.mst = ST_P4;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P4: begin
        if (prefix_hit(3'd4, rx_byte)) nxt.mst = ST_P5;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P5: begin
        if (prefix_hit(3'd5, rx_byte)) nxt.mst = ST_P6;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P6: begin
        if (prefix_hit(3'd6, rx_byte)) nxt.mst = ST_P7;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_P7: begin
        if (prefix_hit(3'd7, rx_byte)) nxt.mst = ST_P8;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      // Branch point after the full prefix
      ST_P8: begin
        if (rx_byte == CH_LBRACE) nxt.mst = ST_PAYLOAD;
        else if (rx_byte == CH_EIGHT) nxt.mst = ST_SKIP;
        else if (rx_byte == CH_UPPER_A) nxt.mst = ST_LINK_T;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      // Payload capture
      ST_PAYLOAD: begin
        if (pend_eff) begin
          res.frame_dropped = 1'b1;
          nxt.pending       = 1'b0;
          nxt.mst           = ST_P0;
          nxt.count         = '0;
        end else begin
          if (room) begin
            res.capture_valid = 1'b1;
            res.capture_index = cur.count[6:0];
            res.capture_byte  = rx_byte;
          end else begin
            res.capture_overflow = 1'b1;
          end
          nxt.count = cnt_inc;
          if (term) begin
            res.frame_done   = 1'b1;
            res.frame_length = cnt_inc;
            nxt.pending      = 1'b1;
            nxt.mst          = ST_P0;
            nxt.count        = '0;
          end
        end
      end
      // Link state sequence
      ST_LINK_T: begin
        if (rx_byte == CH_UPPER_T) nxt.mst = ST_LINK_E;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_LINK_E: begin
        if (rx_byte == CH_UPPER_E) nxt.mst = ST_LINK_COLON;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_LINK_COLON: begin
        if (rx_byte == CH_COLON) nxt.mst = ST_LINK_DIGIT;
        else begin nxt.mst = ST_P0; nxt.count = '0; end
      end
      ST_LINK_DIGIT: begin
        if (rx_byte == CH_ZERO) begin
          nxt.link        = 1'b0;
          res.link_update = 1'b1;
        end else if (rx_byte == CH_ONE) begin
          nxt.link        = 1'b1;
          res.link_update = 1'b1;
        end
        nxt.mst   = ST_P0;
        nxt.count = '0;
      end
      // Discarded byte, and any code that should not occur
      default: begin
        nxt.mst   = ST_P0;
        nxt.count = '0;
      end
    endcase

    res.link_connected = nxt.link;
  end

endmodule

// ===== hdl/cloud_reply_byte_matcher.sv =====
`timescale 1ns / 1ps
// Input beat to result beat: the input register, then the result register.
// Throughput: one byte per cycle while out_ready keeps the result register moving; the state
// update is a single pass through crbm_step. The input stage refills as soon as the result
// register is empty or being taken. Reset (synchronous, rst_n low): matcher idle, count,
// pending and link flags cleared, both stages empty.

module cloud_reply_byte_matcher
  import crbm_pkg::*;
#(
  parameter int CAPTURE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_taken,

  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_capture_valid,
  output logic [6:0] out_capture_index,
  output logic [7:0] out_capture_byte,
  output logic       out_frame_done,
  output logic [7:0] out_frame_length,
  output logic       out_frame_dropped,
  output logic       out_capture_overflow,
  output logic       out_link_update,
  output logic       out_link_connected
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_taken_r;
  logic        out_vld_r;
  crbm_res_t   out_res_r;
  crbm_state_t st_r;
  crbm_state_t st_nxt;
  crbm_res_t   res_nxt;
  logic        advance;

  // Held byte moves into the result register when that has room
  assign advance  = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r  <= in_rx_byte;
      in_taken_r <= in_frame_taken;
    end
  end

  crbm_step #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_step (
    .cur        (st_r),
    .rx_byte    (in_byte_r),
    .frame_taken(in_taken_r),
    .nxt        (st_nxt),
    .res        (res_nxt)
  );

  // Matcher state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mst     <= ST_P0;
      st_r.count   <= '0;
      st_r.pending <= 1'b0;
      st_r.link    <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_capture_valid    = out_res_r.capture_valid;
  assign out_capture_index    = out_res_r.capture_index;
  assign out_capture_byte     = out_res_r.capture_byte;
  assign out_frame_done       = out_res_r.frame_done;
  assign out_frame_length     = out_res_r.frame_length;
  assign out_frame_dropped    = out_res_r.frame_dropped;
  assign out_capture_overflow = out_res_r.capture_overflow;
  assign out_link_update      = out_res_r.link_update;
  assign out_link_connected   = out_res_r.link_connected;

endmodule

// ===== test/crbm_reply_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the reply matcher, predicts every result beat and
// compares it field by field with what the block produces.
module crbm_reply_checker
  import crbm_pkg::*;
#(
  parameter int CAPTURE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_taken,

  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_capture_valid,
  input  logic [6:0] out_capture_index,
  input  logic [7:0] out_capture_byte,
  input  logic       out_frame_done,
  input  logic [7:0] out_frame_length,
  input  logic       out_frame_dropped,
  input  logic       out_capture_overflow,
  input  logic       out_link_update,
  input  logic       out_link_connected,

  output int         fail_count,
  output int         outstanding,
  output int         beats_checked,
  output int         payload_bytes,
  output int         frames_closed,
  output int         frames_dropped,
  output int         overflow_beats,
  output int         link_updates
);

  // Predicted matcher state
  match_st_t  mst        = ST_P0;
  logic [7:0] cap_count  = '0;
  logic       frame_held = 1'b0;
  logic       link_up    = 1'b0;

  crbm_res_t  replies_due[$];

  int fails   = 0;
  int checked = 0;
  int n_bytes = 0;
  int n_done  = 0;
  int n_drop  = 0;
  int n_ovf   = 0;
  int n_link  = 0;

  // Back to the start of the prefix, count cleared
  function automatic void rewind_matcher();
    mst       = ST_P0;
    cap_count = '0;
  endfunction

  // Works out the reply to one received byte and advances the predicted state
  function automatic crbm_res_t predict_reply(input logic [7:0] b, input logic taken);
    crbm_res_t r;
    logic      hit;
    logic      in_prefix;
    r         = '0;
    hit       = 1'b0;
    in_prefix = 1'b1;
    if (taken) frame_held = 1'b0;

    // Prefix positions: three accepted characters each
    case (mst)
      ST_P0: hit = (b == "p") || (b == "E") || (b == "T");
      ST_P1: hit = (b == "a") || (b == "R") || (b == "C");
      ST_P2: hit = (b == "r") || (b == "R") || (b == "M");
      ST_P3: hit = (b == "a") || (b == "o") || (b == "Q");
      ST_P4: hit = (b == "m") || (b == "R") || (b == "T");
      ST_P5: hit = (b == "s") || (b == ":") || (b == "T");
      ST_P6: hit = (b == "\"") || (b == "2") || (b == "S");
      ST_P7: hit = (b == ":") || (b == "0") || (b == "T");
      default: in_prefix = 1'b0;
    endcase

    if (in_prefix) begin
      if (hit) mst = match_st_t'({mst[13:0], 1'b0});
      else rewind_matcher();
    end else begin
      case (mst)
        ST_P8: begin
          if (b == CH_LBRACE) mst = ST_PAYLOAD;
          else if (b == CH_EIGHT) mst = ST_SKIP;
          else if (b == CH_UPPER_A) mst = ST_LINK_T;
          else rewind_matcher();
        end
        ST_PAYLOAD: begin
          if (frame_held) begin
            // previous frame never collected: this one is thrown away
            r.frame_dropped = 1'b1;
            frame_held      = 1'b0;
            rewind_matcher();
          end else begin
            if (cap_count < CAPTURE_DEPTH) begin
              r.capture_valid = 1'b1;
              r.capture_index = cap_count[6:0];
              r.capture_byte  = b;
              cap_count       = cap_count + 8'd1;
            end else begin
              r.capture_overflow = 1'b1;
            end
            if (b == CH_RBRACE || b == CH_LF) begin
              r.frame_done   = 1'b1;
              r.frame_length = cap_count;
              frame_held     = 1'b1;
              rewind_matcher();
            end
          end
        end
        ST_LINK_T: begin
          if (b == CH_UPPER_T) mst = ST_LINK_E;
          else rewind_matcher();
        end
        ST_LINK_E: begin
          if (b == CH_UPPER_E) mst = ST_LINK_COLON;
          else rewind_matcher();
        end
        ST_LINK_COLON: begin
          if (b == CH_COLON) mst = ST_LINK_DIGIT;
          else rewind_matcher();
        end
        ST_LINK_DIGIT: begin
          if (b == CH_ZERO) begin
            link_up       = 1'b0;
            r.link_update = 1'b1;
          end else if (b == CH_ONE) begin
            link_up       = 1'b1;
            r.link_update = 1'b1;
          end
          rewind_matcher();
        end
        default: rewind_matcher();  // skip state swallows one byte
      endcase
    end

    r.link_connected = link_up;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fails++;
    end
  endtask

  // Result beats are checked first, then the accepted input beat is predicted
  always @(posedge clk) begin
    crbm_res_t seen;
    crbm_res_t want;
    if (!rst_n) begin
      mst        = ST_P0;
      cap_count  = '0;
      frame_held = 1'b0;
      link_up    = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_capture_valid, out_capture_index, out_capture_byte, out_frame_done,
                out_frame_length, out_frame_dropped, out_capture_overflow,
                out_link_update, out_link_connected};
        if (replies_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, seen);
          fails++;
        end else begin
          want = replies_due.pop_front();
          checked++;
          check_field("capture_valid", want.capture_valid, seen.capture_valid);
          check_field("capture_index", want.capture_index, seen.capture_index);
          check_field("capture_byte", want.capture_byte, seen.capture_byte);
          check_field("frame_done", want.frame_done, seen.frame_done);
          check_field("frame_length", want.frame_length, seen.frame_length);
          check_field("frame_dropped", want.frame_dropped, seen.frame_dropped);
          check_field("capture_overflow", want.capture_overflow, seen.capture_overflow);
          check_field("link_update", want.link_update, seen.link_update);
          check_field("link_connected", want.link_connected, seen.link_connected);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_reply(in_rx_byte, in_frame_taken);
        replies_due.push_back(want);
        if (want.capture_valid) n_bytes++;
        if (want.frame_done) n_done++;
        if (want.frame_dropped) n_drop++;
        if (want.capture_overflow) n_ovf++;
        if (want.link_update) n_link++;
      end
    end
    fail_count     <= fails;
    outstanding    <= replies_due.size();
    beats_checked  <= checked;
    payload_bytes  <= n_bytes;
    frames_closed  <= n_done;
    frames_dropped <= n_drop;
    overflow_beats <= n_ovf;
    link_updates   <= n_link;
  end

endmodule

// ===== test/cloud_reply_byte_matcher_tb.sv =====
`timescale 1ns / 1ps

module cloud_reply_byte_matcher_tb;
  import crbm_pkg::*;

  localparam int DEPTH       = 128;
  localparam int ITEM_TARGET = 1850;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_EVERY = 600;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte     = '0;
  logic       in_frame_taken = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic       out_capture_valid;
  logic [6:0] out_capture_index;
  logic [7:0] out_capture_byte;
  logic       out_frame_done;
  logic [7:0] out_frame_length;
  logic       out_frame_dropped;
  logic       out_capture_overflow;
  logic       out_link_update;
  logic       out_link_connected;

  int fail_count, outstanding, beats_checked, payload_bytes;
  int frames_closed, frames_dropped, overflow_beats, link_updates;

  int items_sent  = 0;
  int burst_left  = 0;
  int taken_pct   = 100;
  int quiet_count = 0;
  int ready_mode  = 0;
  int mode_left   = 0;
  int ready_phase = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  cloud_reply_byte_matcher #(
    .CAPTURE_DEPTH(DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .in_frame_taken      (in_frame_taken),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_capture_valid   (out_capture_valid),
    .out_capture_index   (out_capture_index),
    .out_capture_byte    (out_capture_byte),
    .out_frame_done      (out_frame_done),
    .out_frame_length    (out_frame_length),
    .out_frame_dropped   (out_frame_dropped),
    .out_capture_overflow(out_capture_overflow),
    .out_link_update     (out_link_update),
    .out_link_connected  (out_link_connected)
  );

  crbm_reply_checker #(
    .CAPTURE_DEPTH(DEPTH)
  ) u_reply_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .in_frame_taken      (in_frame_taken),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_capture_valid   (out_capture_valid),
    .out_capture_index   (out_capture_index),
    .out_capture_byte    (out_capture_byte),
    .out_frame_done      (out_frame_done),
    .out_frame_length    (out_frame_length),
    .out_frame_dropped   (out_frame_dropped),
    .out_capture_overflow(out_capture_overflow),
    .out_link_update     (out_link_update),
    .out_link_connected  (out_link_connected),
    .fail_count          (fail_count),
    .outstanding         (outstanding),
    .beats_checked       (beats_checked),
    .payload_bytes       (payload_bytes),
    .frames_closed       (frames_closed),
    .frames_dropped      (frames_dropped),
    .overflow_beats      (overflow_beats),
    .link_updates        (link_updates)
  );

  // Receiver back-pressure: a mode is held for a while, then another is drawn
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(40, 250);
    end else begin
      mode_left <= mode_left - 1;
    end
    ready_phase <= ready_phase + 1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (ready_phase % 4 == 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog on cycles without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d replies outstanding", $time,
               quiet_count, outstanding);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // One byte on the input channel; bursts of random length, random gaps between
  task automatic put_beat(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_taken <= ($urandom_range(0, 99) < taken_pct);
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Prefix with random alternates; cut < 9 breaks it with a wrong byte there
  task automatic send_prefix(input int cut);
    logic [7:0] b;
    for (int pos = 0; pos < 9; pos++) begin
      if (pos == cut) begin
        if (pos == 8) begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_LBRACE || b == CH_EIGHT || b == CH_UPPER_A);
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == PREFIX_TAB[pos][0] || b == PREFIX_TAB[pos][1] ||
                 b == PREFIX_TAB[pos][2]);
        end
        put_beat(b);
        return;
      end
      if (pos < 8) put_beat(PREFIX_TAB[pos][$urandom_range(0, 2)]);
    end
  endtask

  // Full frame: prefix, brace, payload free of terminators, closing byte
  task automatic send_frame(input int len);
    logic [7:0] b;
    send_prefix(9);
    put_beat(CH_LBRACE);
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_RBRACE || b == CH_LF);
      put_beat(b);
    end
    put_beat($urandom_range(0, 1) ? CH_RBRACE : CH_LF);
  endtask

  task automatic send_link(input logic [7:0] digit);
    send_prefix(9);
    put_beat(CH_UPPER_A);
    put_beat(CH_UPPER_T);
    put_beat(CH_UPPER_E);
    put_beat(CH_COLON);
    put_beat(digit);
  endtask

  // Input stays idle until the checker has seen every predicted reply
  task automatic drain_replies();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int pick;
    int next_drain;
    int sel;
    next_drain = DRAIN_EVERY;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: mismatch at the second position, a frame with extreme bytes
    // closed by a line feed, then a link-up sequence
    put_beat("p");
    put_beat(8'hFF);
    send_prefix(9);
    put_beat(CH_LBRACE);
    put_beat(8'h00);
    put_beat(8'hFF);
    put_beat(CH_LF);
    send_link(CH_ONE);

    // Random: mostly well-formed replies, some broken prefixes and noise
    taken_pct = 30;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_drain) begin
        drain_replies();
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame(($urandom_range(0, 29) == 0) ? $urandom_range(120, 140)
                                                : $urandom_range(0, 24));
      end else if (pick < 60) begin
        sel = $urandom_range(0, 9);
        send_link((sel < 4) ? CH_ZERO : (sel < 8) ? CH_ONE : 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        send_prefix(9);
        put_beat(CH_EIGHT);
        put_beat(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_prefix($urandom_range(0, 8));
      end else begin
        repeat ($urandom_range(1, 4)) put_beat(8'($urandom_range(0, 255)));
      end
    end

    drain_replies();
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("Drove %0d bytes, checked %0d replies: %0d payload bytes, %0d frames closed,",
             items_sent, beats_checked, payload_bytes, frames_closed);
    $display("%0d frames dropped, depth overflow hit on %0d beats, link flag updated %0d times",
             frames_dropped, overflow_beats, link_updates);
    if (outstanding != 0) $display("%0d replies never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/crbm_pkg.sv
hdl/crbm_step.sv
hdl/cloud_reply_byte_matcher.sv
test/crbm_reply_checker.sv
test/cloud_reply_byte_matcher_tb.sv
